// ----- design/rsf_pkg.sv -----
// ----------------------------------------------------------------------------
// rsf_pkg
// Shared constants and types for the record substring filter.
// ----------------------------------------------------------------------------
package rsf_pkg;

   localparam int DEF_PATTERN_BYTES = 56;
   localparam int DEF_FIELD_BYTES   = 50;
   localparam int DEF_INDEX_BITS    = 16;

   localparam int CHAR_W  = 8;
   localparam int INDEX_W = 16;
   localparam int LEN_W   = 6;
   localparam int DATA_W  = 64;
   localparam int ADDR_W  = 6;
   localparam int REG_W   = 3;

   localparam logic [CHAR_W-1:0] FIELD_END = '0;

   // register map, one 64-bit register every 8 bytes
   localparam logic [REG_W-1:0] REG_PATTERN_LAST = 3'd6;
   localparam logic [REG_W-1:0] REG_LENGTH       = 3'd7;

   // pattern length controls handed from the register file to the scanner
   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic             len_ok;
   } len_ctl_type;

endpackage

// ----- design/rsf_req_if.sv -----
// ----------------------------------------------------------------------------
// rsf_req_if
// Character channel: valid/ready handshake with one byte per item.
// ----------------------------------------------------------------------------
interface rsf_req_if;
   logic                       valid;
   logic                       ready;
   logic [rsf_pkg::CHAR_W-1:0] character;

   modport source (output valid, output character, input ready);
   modport sink   (input valid, input character, output ready);
endinterface

// ----- design/rsf_rsp_if.sv -----
// ----------------------------------------------------------------------------
// rsf_rsp_if
// Result channel: valid/ready handshake, one item per record.
// ----------------------------------------------------------------------------
interface rsf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        record_match;
   logic [rsf_pkg::INDEX_W-1:0] record_index;

   modport source (output valid, output record_match, output record_index, input ready);
   modport sink   (input valid, input record_match, input record_index, output ready);
endinterface

// ----- design/record_substring_filter.sv -----
// ----------------------------------------------------------------------------
// record_substring_filter
// Flags records (name field, number field, each zero terminated) whose name
// or number holds the configured pattern.
//
//   channel | dir | handshake          | item
//   --------+-----+--------------------+---------------------------------
//   req     | in  | valid/ready        | character
//   rsp     | out | valid/ready        | record_match, record_index
//   apb     | in  | psel/penable/pready| 64-bit registers at 8*i
//
// One character per cycle while no record end waits on a full result register;
// a result passes through the input register, then the scan update into the result register.
// The scan step is a window shift plus one parallel masked byte compare.
// Synchronous active-high reset clears control state and the pattern and length registers.
// A stalled result holds only the input stage when a record end is waiting;
// characters that close no record keep flowing past a full result register.
// ----------------------------------------------------------------------------
module record_substring_filter #(
   parameter int PATTERN_BYTES = rsf_pkg::DEF_PATTERN_BYTES,
   parameter int FIELD_BYTES   = rsf_pkg::DEF_FIELD_BYTES,
   parameter int INDEX_BITS    = rsf_pkg::DEF_INDEX_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   rsf_req_if.sink                    req,
   rsf_rsp_if.source                  rsp,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [rsf_pkg::ADDR_W-1:0] paddr,
   input  logic [rsf_pkg::DATA_W-1:0] pwdata,
   output logic [rsf_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);
   import rsf_pkg::*;

   logic [PATTERN_BYTES-1:0][CHAR_W-1:0] aligned;
   logic [PATTERN_BYTES-1:0]             mask;
   len_ctl_type                          ctl;

   logic                stage_valid_ff, stage_valid_in;
   logic [CHAR_W-1:0]   stage_char_ff;
   logic                out_valid_ff, out_valid_in;
   logic                out_match_ff;
   logic [INDEX_W-1:0]  out_index_ff;
   logic                accept;
   logic                advance;
   logic                rec_end;
   logic                rec_match;
   logic [INDEX_W-1:0]  rec_index;

   rsf_csr #(
      .PATTERN_BYTES (PATTERN_BYTES),
      .FIELD_BYTES   (FIELD_BYTES)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .aligned (aligned),
      .mask    (mask),
      .ctl     (ctl)
   );

   rsf_scan #(
      .PATTERN_BYTES (PATTERN_BYTES),
      .FIELD_BYTES   (FIELD_BYTES),
      .INDEX_BITS    (INDEX_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .character (stage_char_ff),
      .aligned   (aligned),
      .mask      (mask),
      .ctl       (ctl),
      .rec_end   (rec_end),
      .rec_match (rec_match),
      .rec_index (rec_index)
   );

   // a record end needs a free result slot; other items never wait
   assign advance   = stage_valid_ff && (!rec_end || !out_valid_ff || rsp.ready);
   assign req.ready = !stage_valid_ff || advance;
   assign accept    = req.valid && req.ready;

   always_comb begin
      stage_valid_in = accept || (stage_valid_ff && !advance);
      out_valid_in   = out_valid_ff && !rsp.ready;
      if (advance && rec_end) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_char_ff <= req.character;
      end
      if (advance && rec_end) begin
         out_match_ff <= rec_match;
         out_index_ff <= rec_index;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.record_match = out_match_ff;
   assign rsp.record_index = out_index_ff;

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (advance && rec_end) |-> (!out_valid_ff || rsp.ready))
      else $error("result register overwritten while still pending");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !advance) |=> (stage_valid_ff && $stable(stage_char_ff)))
      else $error("input stage lost a waiting item");

   a_result_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && !(advance && rec_end)) |=> !rsp.valid)
      else $error("taken result shown again");

endmodule

// ----- design/rsf_csr.sv -----
// ----------------------------------------------------------------------------
// rsf_csr
// APB register file for the pattern bytes and length. Also keeps a registered
// copy of the pattern turned around so pattern byte len-1-j sits in lane j,
// lined up with window lane j (newest character in lane 0).
// ----------------------------------------------------------------------------
module rsf_csr #(
   parameter int PATTERN_BYTES = rsf_pkg::DEF_PATTERN_BYTES,
   parameter int FIELD_BYTES   = rsf_pkg::DEF_FIELD_BYTES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [rsf_pkg::ADDR_W-1:0]        paddr,
   input  logic [rsf_pkg::DATA_W-1:0]        pwdata,
   output logic [rsf_pkg::DATA_W-1:0]        prdata,
   output logic                              pready,
   output logic [PATTERN_BYTES-1:0][rsf_pkg::CHAR_W-1:0] aligned,
   output logic [PATTERN_BYTES-1:0]          mask,
   output rsf_pkg::len_ctl_type              ctl
);
   import rsf_pkg::*;

   localparam int PIDX_W = $clog2(PATTERN_BYTES);

   logic [PATTERN_BYTES-1:0][CHAR_W-1:0] pattern_ff, pattern_in;
   logic [LEN_W-1:0]                     length_ff, length_in;
   logic [PATTERN_BYTES-1:0][CHAR_W-1:0] aligned_ff, aligned_in;
   logic [PATTERN_BYTES-1:0]             mask_ff, mask_in;
   len_ctl_type                          ctl_ff, ctl_in;
   logic                                 wr_en;
   logic [REG_W-1:0]                     wr_reg;
   logic [REG_W-1:0]                     rd_reg;
   logic [LEN_W:0]                       src;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign wr_reg = paddr[ADDR_W-1 -: REG_W];
   assign rd_reg = paddr[ADDR_W-1 -: REG_W];

   always_comb begin
      pattern_in = pattern_ff;
      length_in  = length_ff;
      if (wr_en) begin
         if (wr_reg <= REG_PATTERN_LAST) begin
            for (int p = 0; p < PATTERN_BYTES; p++) begin
               if (REG_W'(p / 8) == wr_reg) begin
                  pattern_in[p] = pwdata[(p % 8) * CHAR_W +: CHAR_W];
               end
            end
         end else if (wr_reg == REG_LENGTH) begin
            length_in = pwdata[LEN_W-1:0];
         end
      end
   end

   always_comb begin
      prdata = '0;
      if (rd_reg == REG_LENGTH) begin
         prdata = DATA_W'(length_ff);
      end else begin
         for (int p = 0; p < PATTERN_BYTES; p++) begin
            if (REG_W'(p / 8) == rd_reg) begin
               prdata[(p % 8) * CHAR_W +: CHAR_W] = pattern_ff[p];
            end
         end
      end
   end

   // lane j compares against pattern byte len-1-j
   always_comb begin
      ctl_in.len    = length_ff;
      ctl_in.len_ok = ({1'b0, length_ff} <= (LEN_W+1)'(FIELD_BYTES - 1)) &&
                      ({1'b0, length_ff} <= (LEN_W+1)'(PATTERN_BYTES));
      aligned_in    = '0;
      mask_in       = '0;
      src           = '0;
      for (int j = 0; j < PATTERN_BYTES; j++) begin
         src = {1'b0, length_ff} - (LEN_W+1)'(j + 1);
         if (ctl_in.len_ok && ((LEN_W+1)'(j) < {1'b0, length_ff})) begin
            aligned_in[j] = pattern_ff[src[PIDX_W-1:0]];
            mask_in[j]    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= '0;
         mask_ff    <= '0;
         ctl_ff     <= '{len: '0, len_ok: 1'b1};
      end else begin
         pattern_ff <= pattern_in;
         length_ff  <= length_in;
         mask_ff    <= mask_in;
         ctl_ff     <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      aligned_ff <= aligned_in;
   end

   assign aligned = aligned_ff;
   assign mask    = mask_ff;
   assign ctl     = ctl_ff;

endmodule

// ----- design/rsf_scan.sv -----
// ----------------------------------------------------------------------------
// rsf_scan
// Character window, per-field count and hit flags, record counter. Updates
// once per step; rec_end flags a step that closes a record.
// ----------------------------------------------------------------------------
module rsf_scan #(
   parameter int PATTERN_BYTES = rsf_pkg::DEF_PATTERN_BYTES,
   parameter int FIELD_BYTES   = rsf_pkg::DEF_FIELD_BYTES,
   parameter int INDEX_BITS    = rsf_pkg::DEF_INDEX_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic [rsf_pkg::CHAR_W-1:0]        character,
   input  logic [PATTERN_BYTES-1:0][rsf_pkg::CHAR_W-1:0] aligned,
   input  logic [PATTERN_BYTES-1:0]          mask,
   input  rsf_pkg::len_ctl_type              ctl,
   output logic                              rec_end,
   output logic                              rec_match,
   output logic [rsf_pkg::INDEX_W-1:0]       rec_index
);
   import rsf_pkg::*;

   localparam int CNT_W = $clog2(FIELD_BYTES);

   logic [PATTERN_BYTES-1:0][CHAR_W-1:0] window_ff, window_in;
   logic [CNT_W-1:0]                     count_ff, count_in;
   logic                                 in_number_ff, in_number_in;
   logic                                 name_hit_ff, name_hit_in;
   logic                                 field_hit_ff, field_hit_in;
   logic [INDEX_BITS-1:0]                counter_ff, counter_in;
   logic [PATTERN_BYTES-1:0]             lane_ok;
   logic                                 room;
   logic                                 enough;
   logic [31:0]                          counter_wide;

   assign room = count_ff < CNT_W'(FIELD_BYTES - 1);

   // window lanes beyond the count are never unmasked, so stale bytes from an
   // earlier field need no clearing
   always_comb begin
      window_in = {window_ff[PATTERN_BYTES-2:0], character};
      for (int j = 0; j < PATTERN_BYTES; j++) begin
         lane_ok[j] = !mask[j] || (window_in[j] == aligned[j]);
      end
   end

   assign enough = ((LEN_W+1)'(count_ff) + (LEN_W+1)'(1)) >= {1'b0, ctl.len};

   assign rec_end      = (character == FIELD_END) && in_number_ff;
   assign rec_match    = name_hit_ff || field_hit_ff;
   assign counter_wide = 32'(counter_ff);
   assign rec_index    = counter_wide[INDEX_W-1:0];

   always_comb begin
      count_in     = count_ff;
      in_number_in = in_number_ff;
      name_hit_in  = name_hit_ff;
      field_hit_in = field_hit_ff;
      counter_in   = counter_ff;
      if (character != FIELD_END) begin
         if (room) begin
            count_in = count_ff + CNT_W'(1);
            if (ctl.len_ok && enough && (&lane_ok)) begin
               field_hit_in = 1'b1;
            end
         end
      end else begin
         count_in     = '0;
         field_hit_in = 1'b0;
         if (!in_number_ff) begin
            name_hit_in  = field_hit_ff;
            in_number_in = 1'b1;
         end else begin
            name_hit_in  = 1'b0;
            in_number_in = 1'b0;
            counter_in   = counter_ff + INDEX_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         in_number_ff <= 1'b0;
         name_hit_ff  <= 1'b0;
         field_hit_ff <= 1'b0;
         counter_ff   <= '0;
      end else if (step) begin
         count_ff     <= count_in;
         in_number_ff <= in_number_in;
         name_hit_ff  <= name_hit_in;
         field_hit_ff <= field_hit_in;
         counter_ff   <= counter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && (character != FIELD_END) && room) begin
         window_ff <= window_in;
      end
   end

endmodule
